[rtl/core/fmpq_pkg.sv]
// Shared constants, codes and control types for the FIFO / max priority queue.
`default_nettype none
package fmpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 2;
	localparam int AMT_W    = 32;
	localparam int NUM_W    = 32;
	localparam int STS_W    = 2;

	localparam logic [OP_W-1:0] OP_INSERT        = 2'd0;
	localparam logic [OP_W-1:0] OP_SERVE_OLDEST  = 2'd1;
	localparam logic [OP_W-1:0] OP_SERVE_LARGEST = 2'd2;

	localparam logic [STS_W-1:0] STS_INSERTED = 2'd0;
	localparam logic [STS_W-1:0] STS_SERVED   = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY    = 2'd2;
	localparam logic [STS_W-1:0] STS_REFUSED  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_SRV_SCAN,
		S_SRV_DRAIN,
		S_RESULT
	} fmpq_state_t;

	typedef enum logic [1:0] {
		RES_INSERTED,
		RES_SERVED,
		RES_EMPTY,
		RES_REFUSED
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     ins_step;
		logic     ins_commit;
		logic     srv_step;
		logic     srv_commit;
		logic     res_write;
		res_sel_t res_sel;
	} fmpq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic ctr_max;
		logic slot_free;
		logic idx_last;
	} fmpq_sts_t;

endpackage
`default_nettype wire

[rtl/core/fmpq_if.sv]
// Request and response channel interfaces.
`default_nettype none
interface fmpq_req_if;
	import fmpq_pkg::*;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0]  opcode;
	logic [AMT_W-1:0] amount;
	modport source (output valid, output opcode, output amount, input ready);
	modport sink   (input valid, input opcode, input amount, output ready);
endinterface

interface fmpq_rsp_if;
	import fmpq_pkg::*;
	logic             valid;
	logic             ready;
	logic [STS_W-1:0] status;
	logic [NUM_W-1:0] entry_number;
	modport source (output valid, output status, output entry_number, input ready);
	modport sink   (input valid, input status, input entry_number, output ready);
endinterface
`default_nettype wire

[rtl/core/fifo_and_max_priority_queue.sv]
// Top level: store of entries served oldest-first or largest-amount-first.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | opcode[1:0], amount[31:0]
//   rsp     | out | valid/ready | status[1:0], entry_number[31:0]
//
// One transaction in flight; req.ready is high only while the controller idles.
// Serve: the amount/arrival RAMs are read one slot per cycle, then one drain
// step and one result step. Insert: occupancy bits are walked one per cycle up
// to the lowest free slot index, then one result step. Refused or empty:
// straight to the result step. A held response stalls only the result step.
// Reset (arst_n low) empties the store and zeroes the arrival counter at once.
`default_nettype none
module fifo_and_max_priority_queue import fmpq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fmpq_req_if.sink   req,
	fmpq_rsp_if.source rsp
);

	fmpq_cmd_t cmd;
	fmpq_sts_t sts;

	fmpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.opcode    (req.opcode),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fmpq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (req.opcode),
		.amount       (req.amount),
		.sts          (sts),
		.status       (rsp.status),
		.entry_number (rsp.entry_number)
	);

endmodule
`default_nettype wire

[rtl/core/fmpq_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fmpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/fmpq_dp.sv]
// Datapath: slot storage, occupancy, arrival counter, scan and result registers.
`default_nettype none
module fmpq_dp import fmpq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fmpq_cmd_t        cmd,
	input  wire logic [OP_W-1:0]  opcode,
	input  wire logic [AMT_W-1:0] amount,
	output fmpq_sts_t             sts,
	output logic      [STS_W-1:0] status,
	output logic      [NUM_W-1:0] entry_number
);

	logic [OP_W-1:0]     op_q;
	logic [AMT_W-1:0]    amt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_W-1:0]    ctr_q;
	logic [CAPACITY-1:0] valid_q;

	logic             pend_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [AMT_W-1:0] best_amt_q;
	logic [NUM_W-1:0] best_arr_q;

	logic [STS_W-1:0] status_q;
	logic [NUM_W-1:0] number_q;

	logic [AMT_W-1:0] rd_amt;
	logic [NUM_W-1:0] rd_arr;
	logic [NUM_W-1:0] ctr_next;
	logic             by_amount;
	logic             better;

	assign ctr_next  = ctr_q + 1'b1;
	assign by_amount = (op_q == OP_SERVE_LARGEST);

	fmpq_ram #(.WIDTH(AMT_W), .DEPTH(CAPACITY)) u_amt_ram (
		.clk   (clk),
		.we    (cmd.ins_commit),
		.waddr (idx_q),
		.wdata (amt_q),
		.re    (cmd.srv_step),
		.raddr (idx_q),
		.rdata (rd_amt)
	);

	fmpq_ram #(.WIDTH(NUM_W), .DEPTH(CAPACITY)) u_arr_ram (
		.clk   (clk),
		.we    (cmd.ins_commit),
		.waddr (idx_q),
		.wdata (ctr_next),
		.re    (cmd.srv_step),
		.raddr (idx_q),
		.rdata (rd_arr)
	);

	// arrival numbers are unique, so the tie-break never sees equal arrivals
	always_comb begin
		if (by_amount) begin
			better = (rd_amt > best_amt_q) ||
				((rd_amt == best_amt_q) && (rd_arr < best_arr_q));
		end else begin
			better = (rd_arr < best_arr_q);
		end
	end

	always_comb begin
		sts.empty     = (cnt_q == '0);
		sts.full      = (cnt_q == CNT_W'(CAPACITY));
		sts.ctr_max   = (ctr_q == '1);
		sts.slot_free = !valid_q[idx_q];
		sts.idx_last  = (idx_q == IDX_W'(CAPACITY - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			ctr_q        <= '0;
			valid_q      <= '0;
			pend_s1      <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.srv_step;
			if (cmd.load) begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.ins_step || cmd.srv_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ins_commit) begin
				valid_q[idx_q] <= 1'b1;
				cnt_q          <= cnt_q + 1'b1;
				ctr_q          <= ctr_next;
			end
			if (cmd.srv_commit) begin
				valid_q[best_idx_q] <= 1'b0;
				cnt_q               <= cnt_q - 1'b1;
			end
			if (pend_s1 && vld_s1 && (!best_found_q || better)) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			amt_q <= amount;
		end
		if (cmd.srv_step) begin
			vld_s1 <= valid_q[idx_q];
			idx_s1 <= idx_q;
		end
		if (pend_s1 && vld_s1 && (!best_found_q || better)) begin
			best_idx_q <= idx_s1;
			best_amt_q <= rd_amt;
			best_arr_q <= rd_arr;
		end
		if (cmd.res_write) begin
			case (cmd.res_sel)
				RES_INSERTED: begin
					status_q <= STS_INSERTED;
					number_q <= ctr_q;
				end
				RES_SERVED: begin
					status_q <= STS_SERVED;
					number_q <= best_arr_q;
				end
				RES_EMPTY: begin
					status_q <= STS_EMPTY;
					number_q <= '0;
				end
				default: begin
					status_q <= STS_REFUSED;
					number_q <= '0;
				end
			endcase
		end
	end

	assign status       = status_q;
	assign entry_number = number_q;

endmodule
`default_nettype wire

[rtl/core/fmpq_ctrl.sv]
// Controller: sequences insert and serve scans and owns the response valid.
`default_nettype none
module fmpq_ctrl import fmpq_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire logic [OP_W-1:0] opcode,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire fmpq_sts_t       sts,
	output fmpq_cmd_t            cmd
);

	fmpq_state_t state_q, state_d;
	res_sel_t    kind_q, kind_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= RES_REFUSED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.res_write) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		cmd       = '0;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RESULT;
					case (opcode)
						OP_INSERT: begin
							if (sts.full || sts.ctr_max) begin
								kind_d = RES_REFUSED;
							end else begin
								state_d = S_INS_SCAN;
							end
						end
						OP_SERVE_OLDEST, OP_SERVE_LARGEST: begin
							if (sts.empty) begin
								kind_d = RES_EMPTY;
							end else begin
								state_d = S_SRV_SCAN;
							end
						end
						default: begin
							kind_d = RES_REFUSED;
						end
					endcase
				end
			end
			S_INS_SCAN: begin
				// store not full, so a free slot is always reached
				if (sts.slot_free) begin
					cmd.ins_commit = 1'b1;
					kind_d         = RES_INSERTED;
					state_d        = S_RESULT;
				end else begin
					cmd.ins_step = 1'b1;
				end
			end
			S_SRV_SCAN: begin
				cmd.srv_step = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SRV_DRAIN;
				end
			end
			S_SRV_DRAIN: begin
				// last slot's compare lands this cycle
				kind_d  = RES_SERVED;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.res_write  = 1'b1;
					cmd.res_sel    = kind_q;
					cmd.srv_commit = (kind_q == RES_SERVED);
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/fmpq_checker.sv]
// Port-level assertions for the queue top level, with its bind.
`default_nettype none
module fmpq_checker import fmpq_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [STS_W-1:0] rsp_status,
	input wire logic [NUM_W-1:0] rsp_entry_number
);

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_entry_number))
		else $error("response changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STS_EMPTY || rsp_status == STS_REFUSED) |->
			rsp_entry_number == '0)
		else $error("error response with nonzero entry number");

	a_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STS_INSERTED || rsp_status == STS_SERVED) |->
			rsp_entry_number != '0)
		else $error("insert or serve returned entry number zero");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

endmodule

bind fifo_and_max_priority_queue fmpq_checker u_fmpq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_entry_number (rsp.entry_number)
);
`default_nettype wire

[tb/fifo_and_max_priority_queue_tb.sv]
// Self-checking testbench for the FIFO / max priority queue: directed table, then random.
module fifo_and_max_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fmpq_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
	localparam logic [NUM_W-1:0] NUMBER_LIMIT = '1;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 75;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = CAPACITY + 8;
	localparam int IDLE_LIMIT  = 4 * (LONG_HOLD + CAPACITY + 3 + 16);

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [AMT_W-1:0] amount;
		logic             fixed;
		logic [STS_W-1:0] status;
		logic [NUM_W-1:0] number;
	} script_row_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [NUM_W-1:0] number;
	} outcome_t;

	localparam int SCRIPT_LEN = 24;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_SERVE_OLDEST,  32'h0000_0000, 1'b1, STS_EMPTY,    32'd0},
		'{OP_SERVE_LARGEST, 32'hFFFF_FFFF, 1'b1, STS_EMPTY,    32'd0},
		'{OP_UNUSED,        32'hFFFF_FFFF, 1'b1, STS_REFUSED,  32'd0},
		'{OP_INSERT,        32'hFFFF_FFFF, 1'b1, STS_INSERTED, 32'd1},
		'{OP_INSERT,        32'h0000_0000, 1'b1, STS_INSERTED, 32'd2},
		'{OP_INSERT,        32'hFFFF_FFFF, 1'b1, STS_INSERTED, 32'd3},
		'{OP_INSERT,        32'h0000_0005, 1'b1, STS_INSERTED, 32'd4},
		'{OP_UNUSED,        32'h0000_0000, 1'b1, STS_REFUSED,  32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_OLDEST,  32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_INSERT,        32'h0000_0005, 1'b0, STS_INSERTED, 32'd0},
		'{OP_INSERT,        32'h0000_0007, 1'b0, STS_INSERTED, 32'd0},
		'{OP_INSERT,        32'h0000_0007, 1'b0, STS_INSERTED, 32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_OLDEST,  32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_OLDEST,  32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_INSERT,        32'h8000_0000, 1'b0, STS_INSERTED, 32'd0},
		'{OP_INSERT,        32'h7FFF_FFFF, 1'b0, STS_INSERTED, 32'd0},
		'{OP_INSERT,        32'h0000_0001, 1'b0, STS_INSERTED, 32'd0},
		'{OP_SERVE_LARGEST, 32'h0000_0000, 1'b0, STS_SERVED,   32'd0},
		'{OP_SERVE_OLDEST,  32'h0000_0000, 1'b0, STS_SERVED,   32'd0}
	};

	// insert share per random phase: fill-heavy phases reach a full store, drain-heavy an empty one
	localparam int INSERT_PCT [PHASES] = '{92, 10, 50, 95, 50, 8, 70, 30};

	logic clk;
	logic arst_n;

	fmpq_req_if req_ch();
	fmpq_rsp_if rsp_ch();

	fifo_and_max_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the store
	logic [AMT_W-1:0] held_amount [CAPACITY];
	logic [NUM_W-1:0] held_number [CAPACITY];
	logic             held_valid  [CAPACITY];
	logic [NUM_W-1:0] last_number;

	outcome_t    awaited_results [$];
	script_row_t fixed_answers   [$];

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned n_insert, n_served, n_empty, n_full, n_unused;

	outcome_t    predicted;
	outcome_t    oldest;
	script_row_t answer;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void forecast_outcome(input logic [OP_W-1:0] op,
			input logic [AMT_W-1:0] amt, output outcome_t res);
		int pick;
		pick = -1;
		res.status = STS_REFUSED;
		res.number = '0;
		if (op == OP_INSERT) begin
			for (int i = 0; i < CAPACITY; i++)
				if (!held_valid[i] && pick < 0)
					pick = i;
			// counter exhaustion needs 2^32 - 1 inserts, out of reach in simulation
			if (pick >= 0 && last_number != NUMBER_LIMIT) begin
				last_number++;
				held_amount[pick] = amt;
				held_number[pick] = last_number;
				held_valid[pick]  = 1'b1;
				res.status = STS_INSERTED;
				res.number = last_number;
			end
		end else if (op inside {OP_SERVE_OLDEST, OP_SERVE_LARGEST}) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (held_valid[i]) begin
					if (pick < 0)
						pick = i;
					else if (op == OP_SERVE_LARGEST) begin
						if (held_amount[i] > held_amount[pick] ||
						    (held_amount[i] == held_amount[pick] &&
						     held_number[i] < held_number[pick]))
							pick = i;
					end else if (held_number[i] < held_number[pick])
						pick = i;
				end
			end
			if (pick < 0)
				res.status = STS_EMPTY;
			else begin
				held_valid[pick] = 1'b0;
				res.status = STS_SERVED;
				res.number = held_number[pick];
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// monitor: predict on request transaction, check on response transaction
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			forecast_outcome(req_ch.opcode, req_ch.amount, predicted);
			if (fixed_answers.size() != 0) begin
				answer = fixed_answers.pop_front();
				if (answer.fixed) begin
					predicted.status = answer.status;
					predicted.number = answer.number;
				end
			end
			case (predicted.status)
				STS_INSERTED: n_insert++;
				STS_SERVED:   n_served++;
				STS_EMPTY:    n_empty++;
				default: begin
					if (req_ch.opcode == OP_INSERT)
						n_full++;
					else
						n_unused++;
				end
			endcase
			awaited_results = {awaited_results, predicted};
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0)
				report_mismatch("response with nothing pending", rsp_ch.entry_number, 0);
			else begin
				oldest = awaited_results.pop_front();
				if (rsp_ch.status !== oldest.status)
					report_mismatch("status", 32'(rsp_ch.status), 32'(oldest.status));
				if (rsp_ch.entry_number !== oldest.number)
					report_mismatch("entry_number", rsp_ch.entry_number, oldest.number);
			end
			results_seen++;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// response side: random stalls, two long hold-offs
	initial begin : response_sink
		int unsigned taken;
		int unsigned hold;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 150 || taken == 420)
				hold = LONG_HOLD;
			else
				hold = $urandom_range(0, 8);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			taken++;
		end
	end

	task automatic offer(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt,
			input script_row_t fixed_row, input int unsigned gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fixed_answers = {fixed_answers, fixed_row};
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.amount <= amt;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_all_served();
		req_ch.valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	function automatic logic [AMT_W-1:0] draw_amount();
		logic [AMT_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			2, 3, 4: v = $urandom_range(0, 7);   // narrow range forces ties
			5:       v = 32'd1 << $urandom_range(0, 31);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [OP_W-1:0] draw_opcode(input int insert_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return OP_UNUSED;
		else if (r < 4 + (insert_pct * 96) / 100)
			return OP_INSERT;
		else if ($urandom_range(0, 1))
			return OP_SERVE_LARGEST;
		else
			return OP_SERVE_OLDEST;
	endfunction

	initial begin : stimulus
		script_row_t no_fixed;
		int unsigned gap;
		no_fixed = '0;
		items_sent = 0;
		results_seen = 0;
		mismatches = 0;
		idle_cycles = 0;
		n_insert = 0;
		n_served = 0;
		n_empty = 0;
		n_full = 0;
		n_unused = 0;
		last_number = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			held_amount[i] = '0;
			held_number[i] = '0;
			held_valid[i]  = 1'b0;
		end
		arst_n <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= OP_INSERT;
		req_ch.amount <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			offer(SCRIPT[i].op, SCRIPT[i].amount, SCRIPT[i], $urandom_range(0, 8));

		for (int p = 0; p < PHASES; p++) begin
			// one pause with nothing in flight midway
			if (p == 4)
				wait_all_served();
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				gap = $urandom_range(0, 8);
				offer(draw_opcode(INSERT_PCT[p]), draw_amount(), no_fixed, gap);
			end
		end

		wait_all_served();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("results never returned", 0, awaited_results.size());

		$display("Covered %0d transactions: %0d inserts, %0d serves, %0d empty serves,",
			items_sent, n_insert, n_served, n_empty);
		$display("%0d full-store refusals, %0d unused-opcode refusals, %0d mismatches.",
			n_full, n_unused, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
